// ===== src/tmia_pkg.sv =====
// ----------------------------------------------------------------------------
// tmia_pkg
// Shared types, opcode names and helpers for the typed memory integer ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmia_pkg;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_DIV   = 4'd3,
    OP_MOD   = 4'd4,
    OP_SHL   = 4'd5,
    OP_SHR   = 4'd6,
    OP_EQ    = 4'd7,
    OP_NE    = 4'd8,
    OP_LT    = 4'd9,
    OP_LE    = 4'd10,
    OP_GT    = 4'd11,
    OP_GE    = 4'd12,
    OP_LOAD  = 4'd13,
    OP_STORE = 4'd14,
    OP_MOV   = 4'd15
  } opcode_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DIV0  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [2:0]  elem_type;
    logic [11:0] addr_a;
    logic [63:0] operand_b;
    logic [11:0] addr_c;
  } in_word_t;

  typedef struct packed {
    logic [63:0] load_value;
    logic [1:0]  status;
  } out_word_t;

  // Byte count of an element type; codes 6 and 7 fold onto the byte types
  function automatic logic [3:0] type_bytes(input logic [2:0] ty);
    logic [3:0] nb;
    unique case (ty)
      3'd0, 3'd1: nb = 4'd8;
      3'd2, 3'd3: nb = 4'd4;
      default:    nb = 4'd1;
    endcase
    return nb;
  endfunction

  // Mask covering nb bytes
  function automatic logic [63:0] byte_mask(input logic [3:0] nb);
    logic [63:0] m;
    unique case (nb)
      4'd8:    m = '1;
      4'd4:    m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'h0000_0000_0000_00FF;
    endcase
    return m;
  endfunction

  // Extend a value of nb bytes to 64 bits
  function automatic logic [63:0] extend(input logic [63:0] v, input logic [3:0] nb,
                                         input logic sgn);
    logic [63:0] r;
    unique case (nb)
      4'd8:    r = v;
      4'd4:    r = {{32{sgn & v[31]}}, v[31:0]};
      default: r = {{56{sgn & v[7]}}, v[7:0]};
    endcase
    return r;
  endfunction

endpackage

// ===== src/typed_memory_integer_alu.sv =====
// ----------------------------------------------------------------------------
// typed_memory_integer_alu
// Executes one typed instruction per input word on a byte-wide data memory.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_     | in  | in_valid/in_stall  | in_word  (in_word_t)
//  out_    | out | out_valid/out_stall| out_word (out_word_t)
//
//  The memory has one byte port, so each instruction moves one byte a cycle:
//  operands are read n bytes each, results written as n bytes (one for compares).
//  Mul and div/mod iterate on a shift-add / shift-subtract unit after the reads;
//  a zero divisor ends after the operand reads with no write. Range errors
//  skip the memory and go straight to the result word.
//  in_stall is high from acceptance until the result word is taken.
//  Reset clears the sequencer only; memory content is undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module typed_memory_integer_alu
  import tmia_pkg::*;
#(
  parameter int MEM_BYTES = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
  localparam logic [63:0] MEM_SIZE = 64'(MEM_BYTES);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD1  = 6'b000010,
    S_RD2  = 6'b000100,
    S_CALC = 6'b001000,
    S_WR   = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  logic [7:0] mem [MEM_BYTES];

  state_t      state_r, state_nxt;
  opcode_t     op_r, op_nxt;
  logic        sgn_r, sgn_nxt;
  logic [3:0]  n_r, n_nxt;
  logic [3:0]  wn_r, wn_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] ra_r, ra_nxt;
  logic [63:0] rb_r, rb_nxt;
  logic [63:0] wc_r, wc_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] y_r, y_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] res_r, res_nxt;
  logic        nx_r, nx_nxt;
  logic        ny_r, ny_nxt;
  logic [63:0] lv_r, lv_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [7:0]  rdata_r;

  logic [63:0] ptr;
  logic        mem_we;
  logic [7:0]  mem_wdata;

  // Decode of the incoming word
  logic [3:0]  in_n, in_cn;
  logic        a_ok, b_ok, c_ok;
  opcode_t     in_op;

  // Datapath helpers
  logic [63:0] m, sx, sy;
  logic [6:0]  wbits;
  logic        big, t;
  logic [64:0] rem_sh;
  logic        ge;
  logic [63:0] diff;

  assign in_op = opcode_t'(in_word.opcode);
  assign in_n  = type_bytes(in_word.elem_type);
  assign in_cn = (in_word.opcode <= OP_SHR) ? in_n : 4'd1;
  assign a_ok  = {52'd0, in_word.addr_a} <= MEM_SIZE - 64'(in_n);
  assign b_ok  = in_word.operand_b <= MEM_SIZE - 64'(in_n);
  assign c_ok  = {52'd0, in_word.addr_c} <= MEM_SIZE - 64'(in_cn);

  assign m     = byte_mask(n_r);
  assign sx    = extend(x_r, n_r, sgn_r);
  assign sy    = extend(y_r, n_r, sgn_r);
  assign wbits = {n_r, 3'b000};
  assign big   = y_r >= 64'(wbits);

  // Shift-subtract step for division and modulo
  assign rem_sh = {acc_r, x_r[63]};
  assign ge     = rem_sh >= {1'b0, y_r};
  assign diff   = rem_sh[63:0] - y_r;

  // Compare result
  always_comb begin
    unique case (op_r)
      OP_EQ:   t = x_r == y_r;
      OP_NE:   t = x_r != y_r;
      OP_LT:   t = sgn_r ? ($signed(sx) <  $signed(sy)) : (x_r <  y_r);
      OP_LE:   t = sgn_r ? ($signed(sx) <= $signed(sy)) : (x_r <= y_r);
      OP_GT:   t = sgn_r ? ($signed(sx) >  $signed(sy)) : (x_r >  y_r);
      OP_GE:   t = sgn_r ? ($signed(sx) >= $signed(sy)) : (x_r >= y_r);
      default: t = 1'b0;
    endcase
  end

  // Byte pointer of the memory port
  always_comb begin
    unique case (state_r)
      S_RD2:   ptr = rb_r + 64'(cnt_r);
      S_WR:    ptr = wc_r + 64'(cnt_r);
      default: ptr = ra_r + 64'(cnt_r);
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    sgn_nxt    = sgn_r;
    n_nxt      = n_r;
    wn_nxt     = wn_r;
    cnt_nxt    = cnt_r;
    ra_nxt     = ra_r;
    rb_nxt     = rb_r;
    wc_nxt     = wc_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    acc_nxt    = acc_r;
    res_nxt    = res_r;
    nx_nxt     = nx_r;
    ny_nxt     = ny_r;
    lv_nxt     = lv_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    mem_wdata  = res_r[{cnt_r[2:0], 3'b000} +: 8];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_op;
          sgn_nxt    = in_word.elem_type[0];
          n_nxt      = in_n;
          cnt_nxt    = '0;
          x_nxt      = '0;
          y_nxt      = '0;
          lv_nxt     = '0;
          status_nxt = ST_OK;
          ra_nxt     = {52'd0, in_word.addr_a};
          rb_nxt     = in_word.operand_b;
          wc_nxt     = {52'd0, in_word.addr_c};
          wn_nxt     = in_cn;
          state_nxt  = S_RD1;
          unique case (in_op)
            OP_LOAD: begin
              if (!a_ok) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_OUT;
              end
            end
            OP_STORE: begin
              res_nxt = in_word.operand_b;
              wc_nxt  = {52'd0, in_word.addr_a};
              wn_nxt  = in_n;
              if (!a_ok) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_OUT;
              end else begin
                state_nxt = S_WR;
              end
            end
            OP_MOV: begin
              ra_nxt = in_word.operand_b;
              wc_nxt = {52'd0, in_word.addr_a};
              wn_nxt = in_n;
              if (!a_ok || !b_ok) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_OUT;
              end
            end
            default: begin
              if (!a_ok || !b_ok || !c_ok) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_OUT;
              end
            end
          endcase
        end
      end

      // Gather first operand, one byte behind the issued address
      S_RD1: begin
        if (cnt_r != '0) x_nxt[{cnt_r[2:0] - 3'd1, 3'b000} +: 8] = rdata_r;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == {3'd0, n_r}) begin
          cnt_nxt = '0;
          unique case (op_r)
            OP_LOAD: begin
              lv_nxt    = extend(x_nxt, n_r, sgn_r);
              state_nxt = S_OUT;
            end
            OP_MOV: begin
              res_nxt   = x_nxt;
              state_nxt = S_WR;
            end
            default: state_nxt = S_RD2;
          endcase
        end
      end

      // Gather second operand
      S_RD2: begin
        if (cnt_r != '0) y_nxt[{cnt_r[2:0] - 3'd1, 3'b000} +: 8] = rdata_r;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == {3'd0, n_r}) begin
          cnt_nxt   = '0;
          state_nxt = S_CALC;
        end
      end

      S_CALC: begin
        cnt_nxt = cnt_r + 7'd1;
        unique case (op_r)
          OP_MUL: begin
            if (cnt_r == 7'd0) begin
              acc_nxt = '0;
            end else if (cnt_r == 7'd65) begin
              res_nxt   = acc_r;
              cnt_nxt   = '0;
              state_nxt = S_WR;
            end else begin
              // Shift-add step
              if (y_r[0]) acc_nxt = acc_r + x_r;
              x_nxt = {x_r[62:0], 1'b0};
              y_nxt = {1'b0, y_r[63:1]};
            end
          end
          OP_DIV, OP_MOD: begin
            if (cnt_r == 7'd0) begin
              if (y_r == '0) begin
                status_nxt = ST_DIV0;
                state_nxt  = S_OUT;
              end
              nx_nxt  = sgn_r & sx[63];
              ny_nxt  = sgn_r & sy[63];
              x_nxt   = (sgn_r & sx[63]) ? ((64'd0 - x_r) & m) : x_r;
              y_nxt   = (sgn_r & sy[63]) ? ((64'd0 - y_r) & m) : y_r;
              acc_nxt = '0;
            end else if (cnt_r == 7'd65) begin
              // Fix signs: quotient toward zero, remainder follows dividend
              if (op_r == OP_DIV) res_nxt = (nx_r ^ ny_r) ? (64'd0 - x_r) : x_r;
              else                res_nxt = nx_r ? (64'd0 - acc_r) : acc_r;
              cnt_nxt   = '0;
              state_nxt = S_WR;
            end else begin
              // Restoring shift-subtract step
              acc_nxt = ge ? diff : rem_sh[63:0];
              x_nxt   = {x_r[62:0], ge};
            end
          end
          default: begin
            unique case (op_r)
              OP_ADD:  res_nxt = x_r + y_r;
              OP_SUB:  res_nxt = x_r - y_r;
              OP_SHL:  res_nxt = big ? '0 : (x_r << y_r[5:0]);
              OP_SHR: begin
                if (sgn_r) res_nxt = big ? {64{sx[63]}} : 64'($signed(sx) >>> y_r[5:0]);
                else       res_nxt = big ? '0 : (x_r >> y_r[5:0]);
              end
              default: res_nxt = {63'd0, t};
            endcase
            cnt_nxt   = '0;
            state_nxt = S_WR;
          end
        endcase
      end

      // Write result bytes, low byte first
      S_WR: begin
        mem_we  = 1'b1;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == {3'd0, wn_r - 4'd1}) begin
          cnt_nxt   = '0;
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Hold operands and results
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    sgn_r    <= sgn_nxt;
    n_r      <= n_nxt;
    wn_r     <= wn_nxt;
    ra_r     <= ra_nxt;
    rb_r     <= rb_nxt;
    wc_r     <= wc_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    acc_r    <= acc_nxt;
    res_r    <= res_nxt;
    nx_r     <= nx_nxt;
    ny_r     <= ny_nxt;
    lv_r     <= lv_nxt;
    status_r <= status_nxt;
  end

  // Data memory, one byte port
  always_ff @(posedge clk) begin
    if (mem_we) mem[ptr[AW-1:0]] <= mem_wdata;
    rdata_r <= mem[ptr[AW-1:0]];
  end

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = (state_r == S_OUT);
  assign out_word.load_value = lv_r;
  assign out_word.status     = status_r;

endmodule

// ===== dv/tb_typed_memory_integer_alu.sv =====
// ----------------------------------------------------------------------------
// tb_typed_memory_integer_alu
// Self-checking bench for the typed memory integer ALU.
// The memory is filled by stores first, so every later read hits written
// bytes. A directed part then covers the corner cases, and a random part
// follows. Each accepted word is predicted in the bench and compared with
// the result words. The sender idles in bursts and the receiver stalls
// on a pattern of its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_typed_memory_integer_alu;
  import tmia_pkg::*;

  localparam int MEM_SIZE = 4096;
  localparam int RAND_ITEMS = 1000;

  typedef struct {
    in_word_t w;
    bit       drain;
  } pend_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  typed_memory_integer_alu #(.MEM_BYTES(MEM_SIZE)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  pend_t     pending_q[$];
  out_word_t result_q[$];
  logic [7:0] shadow_mem[MEM_SIZE];
  int        mismatches;
  int        burst_left;
  int        gap_left;
  int        stall_left;
  int        run_left;
  bit        word_taken;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow memory access, little endian
  function automatic logic [63:0] shadow_read(logic [63:0] addr, int nb);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < nb; i++) v[8*i +: 8] = shadow_mem[addr + i];
    return v;
  endfunction

  function automatic void shadow_write(logic [63:0] addr, int nb, logic [63:0] v);
    for (int i = 0; i < nb; i++) shadow_mem[addr + i] = v[8*i +: 8];
  endfunction

  function automatic bit fits(logic [63:0] addr, int nb);
    return addr <= 64'(MEM_SIZE - nb);
  endfunction

  // Execute one instruction on the shadow memory and build its result word
  function automatic out_word_t execute_instr(in_word_t w);
    out_word_t  res;
    opcode_t    op;
    int         nb, cn, wd;
    bit         sgn, nx, ny, cmp;
    logic [63:0] m, sb, x, y, r, ux, uy, bias;
    op  = opcode_t'(w.opcode);
    nb  = (w.elem_type < 2) ? 8 : (w.elem_type < 4) ? 4 : 1;
    sgn = w.elem_type[0];
    wd  = nb * 8;
    m   = (nb == 8) ? '1 : ((64'd1 << wd) - 1);
    sb  = 64'd1 << (wd - 1);
    res = '{load_value: '0, status: ST_OK};
    if (op <= OP_GE) begin
      cn = (op <= OP_SHR) ? nb : 1;
      if (!fits(w.addr_a, nb) || !fits(w.operand_b, nb) || !fits(w.addr_c, cn)) begin
        res.status = ST_RANGE;
      end else begin
        x = shadow_read(w.addr_a, nb) & m;
        y = shadow_read(w.operand_b, nb) & m;
        r = '0;
        case (op)
          OP_ADD: r = x + y;
          OP_SUB: r = x - y;
          OP_MUL: r = x * y;
          OP_DIV, OP_MOD: begin
            if (y != 0) begin
              if (!sgn) begin
                r = (op == OP_DIV) ? x / y : x % y;
              end else begin
                nx = (x & sb) != 0;
                ny = (y & sb) != 0;
                ux = nx ? ((-x) & m) : x;
                uy = ny ? ((-y) & m) : y;
                if (op == OP_DIV) r = (nx != ny) ? -(ux / uy) : ux / uy;
                else r = nx ? -(ux % uy) : ux % uy;
              end
            end
          end
          OP_SHL: r = (y >= wd) ? '0 : (x << y);
          OP_SHR: begin
            if (y >= wd) begin
              r = (sgn && (x & sb) != 0) ? m : '0;
            end else begin
              r = x >> y;
              if (sgn && (x & sb) != 0) r |= m & ~(m >> y);
            end
          end
          default: begin
            bias = sgn ? sb : '0;
            x ^= bias;
            y ^= bias;
            case (op)
              OP_EQ:   cmp = x == y;
              OP_NE:   cmp = x != y;
              OP_LT:   cmp = x < y;
              OP_LE:   cmp = x <= y;
              OP_GT:   cmp = x > y;
              default: cmp = x >= y;
            endcase
            r = {63'd0, cmp};
          end
        endcase
        if ((op == OP_DIV || op == OP_MOD) && y == 0) res.status = ST_DIV0;
        else shadow_write(w.addr_c, cn, r);
      end
    end else if (op == OP_LOAD) begin
      if (!fits(w.addr_a, nb)) begin
        res.status = ST_RANGE;
      end else begin
        x = shadow_read(w.addr_a, nb) & m;
        res.load_value = (sgn && (x & sb) != 0) ? (x | ~m) : x;
      end
    end else if (op == OP_STORE) begin
      if (!fits(w.addr_a, nb)) res.status = ST_RANGE;
      else shadow_write(w.addr_a, nb, w.operand_b & m);
    end else begin
      if (!fits(w.addr_a, nb) || !fits(w.operand_b, nb)) res.status = ST_RANGE;
      else shadow_write(w.addr_a, nb, shadow_read(w.operand_b, nb));
    end
    return res;
  endfunction

  function automatic void push_word(logic [3:0] op, logic [2:0] ty, logic [11:0] a,
                                    logic [63:0] b, logic [11:0] c);
    pend_t p;
    p.w = '{opcode: op, elem_type: ty, addr_a: a, operand_b: b, addr_c: c};
    p.drain = 1'b0;
    pending_q.push_back(p);
  endfunction

  function automatic void push_drain();
    pend_t p;
    p.w = '0;
    p.drain = 1'b1;
    pending_q.push_back(p);
  endfunction

  // Pick an operand value that tends toward the interesting corners
  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = '0;
      1: v = '1;
      2: v = 64'h8000_0000_0000_0000;
      3: v = 64'h0000_0000_8000_0000;
      4: v = 64'h80;
      5: v = 64'($urandom_range(0, 70));
      6: v = 64'($urandom_range(0, 3));
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // Address for an access of nb bytes; now and then past the end
  function automatic logic [63:0] pick_addr(int nb, bit wide);
    logic [63:0] v;
    case ($urandom_range(0, 19))
      0: v = 64'($urandom_range(MEM_SIZE - 8, MEM_SIZE - 1));
      1: v = wide ? {$urandom, $urandom} : 64'($urandom_range(0, MEM_SIZE - 1));
      2, 3, 4, 5: v = 64'($urandom_range(0, 63));
      default: v = 64'($urandom_range(0, MEM_SIZE - nb));
    endcase
    return v;
  endfunction

  // Fill the stimulus queue
  initial begin
    logic [2:0]  ty;
    logic [3:0]  op;
    int          nb;
    logic [63:0] a, c;
    // fill every byte so that no read sees unwritten memory
    for (int i = 0; i < MEM_SIZE / 8; i++)
      push_word(OP_STORE, 3'd0, 12'(i * 8), {$urandom, $urandom}, 12'd0);
    push_drain();
    // signed corner operands
    push_word(OP_STORE, 3'd1, 12'h100, 64'h8000_0000_0000_0000, 12'd0);
    push_word(OP_STORE, 3'd1, 12'h108, '1, 12'd0);
    push_word(OP_STORE, 3'd1, 12'h110, 64'd0, 12'd0);
    push_word(OP_STORE, 3'd1, 12'h118, 64'd64, 12'd0);
    push_word(OP_DIV,   3'd1, 12'h100, 64'h108, 12'h200);
    push_word(OP_MOD,   3'd1, 12'h100, 64'h108, 12'h208);
    push_word(OP_DIV,   3'd0, 12'h100, 64'h110, 12'h210);
    push_word(OP_MOD,   3'd3, 12'h100, 64'h110, 12'h210);
    push_word(OP_SHR,   3'd1, 12'h100, 64'h118, 12'h218);
    push_word(OP_SHL,   3'd0, 12'h108, 64'h118, 12'h220);
    push_word(OP_STORE, 3'd3, 12'h120, 64'h8000_0000, 12'd0);
    push_word(OP_STORE, 3'd3, 12'h124, 64'hFFFF_FFFF, 12'd0);
    push_word(OP_DIV,   3'd3, 12'h120, 64'h124, 12'h228);
    push_word(OP_LT,    3'd5, 12'h100 + 12'd7, 64'h110, 12'hFFF);
    push_word(OP_LOAD,  3'd7, 12'h107, 64'd0, 12'd0);
    push_word(OP_LOAD,  3'd6, 12'hFFF, 64'd0, 12'd0);
    push_word(OP_LOAD,  3'd0, 12'hFF9, 64'd0, 12'd0);
    push_word(OP_STORE, 3'd0, 12'hFF8, '1, 12'd0);
    push_word(OP_MOV,   3'd2, 12'h201, 64'h200, 12'd0);
    push_word(OP_MOV,   3'd0, 12'h000, '1, 12'd0);
    push_word(OP_ADD,   3'd0, 12'hFF8, 64'hFF8, 12'hFFC);
    for (int k = 0; k <= 12; k++)
      push_word(4'(k), 3'(k % 8), 12'h100, 64'h108, 12'h300);
    push_drain();
    // random part: mostly legal operations on cornered data
    for (int i = 0; i < RAND_ITEMS; i++) begin
      ty = 3'($urandom_range(0, 7));
      nb = (ty < 2) ? 8 : (ty < 4) ? 4 : 1;
      op = 4'($urandom_range(0, 15));
      a  = pick_addr(nb, 1'b0);
      c  = pick_addr(nb, 1'b0);
      if ($urandom_range(0, 3) == 0)
        push_word(OP_STORE, ty, 12'(a), pick_value(), 12'(c));
      else if (op == OP_STORE)
        push_word(op, ty, 12'(a), pick_value(), 12'(c));
      else
        push_word(op, ty, 12'(a), pick_addr(nb, 1'b1), 12'(c));
      if (i == RAND_ITEMS / 2) push_drain();
    end
  end

  // Reset
  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Driver: present the queue head in bursts with gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_word    <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      word_taken = in_valid && !in_stall;
      if (word_taken) begin
        result_q.push_back(execute_instr(in_word));
        void'(pending_q.pop_front());
      end
      if (!in_valid || word_taken) begin
        if (pending_q.size() > 0 && pending_q[0].drain) begin
          in_valid <= 1'b0;
          if (result_q.size() == 0) void'(pending_q.pop_front());
        end else if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_q.size() > 0) begin
          in_valid <= 1'b1;
          in_word  <= pending_q[0].w;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken result word, stall in runs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      run_left   <= 0;
      mismatches <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result word: load_value=%h status=%0d",
                     out_word.load_value, out_word.status);
          mismatches <= mismatches + 1;
        end else if (out_word.load_value !== result_q[0].load_value ||
                     out_word.status !== result_q[0].status) begin
          if (mismatches < 10)
            $display("mismatch: expected load_value=%h status=%0d, got load_value=%h status=%0d",
                     result_q[0].load_value, result_q[0].status,
                     out_word.load_value, out_word.status);
          mismatches <= mismatches + 1;
          void'(result_q.pop_front());
        end else begin
          void'(result_q.pop_front());
        end
      end
      if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (run_left > 0) begin
        out_stall <= 1'b0;
        run_left  <= run_left - 1;
      end else begin
        out_stall  <= 1'b0;
        stall_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
        run_left   <= $urandom_range(0, 30);
      end
    end
  end

  // End of run
  initial begin
    @(posedge rst_n);
    wait (pending_q.size() == 0 && !in_valid);
    wait (result_q.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("** typed_memory_integer_alu: PASSED **");
    end else begin
      $display("** typed_memory_integer_alu: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("** typed_memory_integer_alu: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
src/tmia_pkg.sv
src/typed_memory_integer_alu.sv
dv/tb_typed_memory_integer_alu.sv
